/* src/mstg_pkg.sv */
// mstg_pkg: shared types, codes and constants of the sinusoid table generator
// depends on nothing; used by the top level and mstg_cordic under src

package mstg_pkg;

    // item kinds
    typedef enum logic [2:0] {
        K_TICK      = 3'd0,
        K_APPEND    = 3'd1,
        K_OVERWRITE = 3'd2,
        K_DELETE    = 3'd3,
        K_RESTART   = 3'd4
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // waveform types, anything else is tangent
    localparam logic [1:0] WAVE_SIN = 2'd0;
    localparam logic [1:0] WAVE_COS = 2'd1;
    localparam logic [1:0] WAVE_TAN = 2'd2;

    // configuration register index (address bit 2)
    localparam logic REG_STEP_X  = 1'b0;
    localparam logic REG_START_X = 1'b1;

    localparam logic [31:0] STEP_X_RESET  = 32'd6554;
    localparam logic [31:0] START_X_RESET = 32'd0;

    // one table entry
    typedef struct packed {
        logic [1:0]         wave;
        logic signed [23:0] amp;
        logic signed [23:0] rate;
        logic signed [19:0] phase;
        logic signed [23:0] level;
    } entry_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LATCH,
        S_MUL_ANG,
        S_REDUCE,
        S_FOLD,
        S_CORDIC,
        S_DIV,
        S_MUL_OUT,
        S_DEL_READ,
        S_DEL_WRITE
    } state_t;

    // angle constants, Q.32 radians
    localparam logic signed [35:0] TWO_PI_Q32  = 36'sd26986075409;
    localparam logic signed [35:0] PI_Q32      = 36'sd13493037705;
    localparam logic signed [35:0] HALF_PI_Q32 = 36'sd6746518852;
    // multiple of 2*pi that makes any angle sum positive
    localparam int REDUCE_SHIFT = 23;
    localparam logic [59:0] ANGLE_OFS = 60'(TWO_PI_Q32) << REDUCE_SHIFT;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [31:0] TAN_MAX = 32'sd2147483647;

    // rounded atan(2^-i) in Q2.30
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0:  a = 32'd843314857;
            5'd1:  a = 32'd497837830;
            5'd2:  a = 32'd263043837;
            5'd3:  a = 32'd133525159;
            5'd4:  a = 32'd67021687;
            5'd5:  a = 32'd33543516;
            5'd6:  a = 32'd16775851;
            5'd7:  a = 32'd8388437;
            5'd8:  a = 32'd4194283;
            5'd9:  a = 32'd2097149;
            5'd31: a = 32'd0;
            default: a = 32'd1 << (5'd30 - i);
        endcase
        return a;
    endfunction

    // clamp to 32 bit signed
    function automatic logic [31:0] sat32(input logic signed [43:0] v);
        logic [31:0] r;
        if (v > 44'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -44'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* src/multichannel_sinusoid_table_generator.sv */
// multichannel_sinusoid_table_generator: top level, entry table, sequencer, apb registers
// depends on mstg_pkg, mstg_ram, mstg_mul, mstg_div, mstg_cordic

// Holds up to MAX_ENTRIES waveform entries (type, amplitude, angular rate, phase,
// level) and on a tick emits A*f(w*x+C)+h for each entry in table order, then
// advances x by step_x. An item is taken when start is high and busy is low.
// Results appear on result_valid for one cycle each and cannot be held off.
// Append, overwrite and restart give their single result the cycle after the
// transfer and leave the block ready at once. Delete moves each later entry down
// one slot, reading it and then writing it, then reports. A tick takes each entry
// through table read, angle multiply, modulo-2*pi reduction, folding, cordic and
// output multiply, with a tangent divide before the output multiply when the
// cosine is not zero; the multiplier is bit-serial and the reducer and divider
// work one bit per cycle. A tick on an empty table only advances x. The entry
// table has no reset; only entries below the live count are ever used.

module multichannel_sinusoid_table_generator #(
    parameter int MAX_ENTRIES  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // item port
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [3:0]  entry_index,
    input  logic [1:0]  wave_type,
    input  logic [23:0] amplitude,
    input  logic [23:0] angular_rate,
    input  logic [19:0] phase,
    input  logic [23:0] level,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // results
    output logic        result_valid,
    output logic [3:0]  result_index,
    output logic [31:0] value,
    output logic [1:0]  status,
    output logic        last
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // control and configuration state
    mstg_pkg::state_t  state_reg, state_next;
    logic [31:0]       step_reg, step_next;
    logic [31:0]       startx_reg, startx_next;
    logic [31:0]       pos_reg, pos_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     ent_reg, ent_next;
    logic              res_valid_reg, res_valid_next;

    // payload registers
    logic [31:0]         x_reg, x_next;
    mstg_pkg::entry_t    ent_data_reg, ent_data_next;
    logic [58:0]         rem_reg, rem_next;
    logic [57:0]         dsr_reg, dsr_next;
    logic [4:0]          red_cnt_reg, red_cnt_next;
    logic                neg_reg, neg_next;
    logic                tan_reg, tan_next;
    logic                tsign_reg, tsign_next;
    logic [3:0]          del_idx_reg, del_idx_next;
    logic [3:0]          res_index_reg, res_index_next;
    logic [31:0]         res_value_reg, res_value_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic                res_last_reg, res_last_next;

    // ram port
    logic                ram_we;
    logic [IW-1:0]       ram_waddr, ram_raddr;
    mstg_pkg::entry_t    ram_wdata, ram_rdata;

    // arithmetic units
    logic                mul_start, mul_done;
    logic signed [33:0]  mul_mcand;
    logic signed [23:0]  mul_mplier;
    logic signed [57:0]  mul_prod;
    logic                div_start, div_done, div_ovf;
    logic [30:0]         div_quot;
    logic                cor_start, cor_done;
    logic signed [33:0]  cor_cos, cor_sin;

    // datapath between the units
    logic                item_xfer, cfg_wr;
    logic [31:0]         idx_ext, cnt_ext;
    logic                idx_ok, tbl_full;
    logic [31:0]         ent_ext;
    mstg_pkg::entry_t    in_entry;
    logic signed [59:0]  ang_sum;
    logic [34:0]         rem_lo;
    logic signed [35:0]  r_base, r_fold;
    logic                fold_neg;
    logic signed [33:0]  z_fold;
    logic signed [33:0]  fx, fy;
    logic [33:0]         abs_x, abs_y;
    logic signed [31:0]  t_mag, t_val, t_pole;
    logic signed [57:0]  rnd_sc, rnd_tn;
    logic signed [43:0]  out_sum;
    logic [31:0]         out_value;
    logic                ent_last;

    // address of the slot after the given one
    function automatic logic [IW-1:0] ent_next_addr(input logic [CW-1:0] e);
        logic [31:0] n;
        n = 32'(e) + 32'd1;
        return n[IW-1:0];
    endfunction

    assign item_xfer = start && !busy;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == mstg_pkg::REG_START_X) ? startx_reg : step_reg;

    assign idx_ext  = {28'd0, entry_index};
    assign cnt_ext  = 32'(count_reg);
    assign idx_ok   = idx_ext < cnt_ext;
    assign tbl_full = count_reg == CW'(MAX_ENTRIES);
    assign ent_ext  = 32'(ent_reg);
    assign ent_last = (ent_reg + 1'b1) == count_reg;

    assign in_entry.wave  = wave_type;
    assign in_entry.amp   = amplitude;
    assign in_entry.rate  = angular_rate;
    assign in_entry.phase = phase;
    assign in_entry.level = level;

    // angle w*x + C in Q.32, shifted positive by a multiple of 2*pi
    assign ang_sum = $signed({{2{mul_prod[57]}}, mul_prod})
                   + $signed({{24{ent_data_reg.phase[19]}}, ent_data_reg.phase, 16'd0})
                   + $signed(mstg_pkg::ANGLE_OFS);

    // wrap into [-pi, pi) then fold into [-pi/2, pi/2]
    assign rem_lo = rem_reg[34:0];
    assign r_base = ($signed({1'b0, rem_lo}) >= mstg_pkg::PI_Q32)
                  ? $signed({1'b0, rem_lo}) - mstg_pkg::TWO_PI_Q32
                  : $signed({1'b0, rem_lo});

    always_comb
    begin
        fold_neg = 1'b0;
        r_fold   = r_base;
        if (r_base > mstg_pkg::HALF_PI_Q32)
        begin
            r_fold   = r_base - mstg_pkg::PI_Q32;
            fold_neg = 1'b1;
        end
        else if (r_base < -mstg_pkg::HALF_PI_Q32)
        begin
            r_fold   = r_base + mstg_pkg::PI_Q32;
            fold_neg = 1'b1;
        end
    end

    assign z_fold = r_fold[35:2];

    // cordic outputs with the fold sign applied
    assign fx    = neg_reg ? -cor_cos : cor_cos;
    assign fy    = neg_reg ? -cor_sin : cor_sin;
    assign abs_x = fx[33] ? 34'(-fx) : 34'(fx);
    assign abs_y = fy[33] ? 34'(-fy) : 34'(fy);

    // tangent, truncated toward zero, clamped at the poles
    assign t_pole = fy[33] ? -mstg_pkg::TAN_MAX : mstg_pkg::TAN_MAX;
    assign t_mag  = div_ovf ? mstg_pkg::TAN_MAX : $signed({1'b0, div_quot});
    assign t_val  = tsign_reg ? -t_mag : t_mag;

    // output scaling with round half up, then level and clamp
    assign rnd_sc  = mul_prod + (58'sd1 <<< 29);
    assign rnd_tn  = mul_prod + (58'sd1 <<< 15);
    assign out_sum = (tan_reg ? $signed({{2{rnd_tn[57]}}, rnd_tn[57:16]})
                              : $signed({{16{rnd_sc[57]}}, rnd_sc[57:30]}))
                   + $signed({{20{ent_data_reg.level[23]}}, ent_data_reg.level});
    assign out_value = mstg_pkg::sat32(out_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mstg_pkg::S_IDLE;
            step_reg      <= mstg_pkg::STEP_X_RESET;
            startx_reg    <= mstg_pkg::START_X_RESET;
            pos_reg       <= mstg_pkg::START_X_RESET;
            count_reg     <= '0;
            ent_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            startx_reg    <= startx_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            ent_reg       <= ent_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        ent_data_reg   <= ent_data_next;
        rem_reg        <= rem_next;
        dsr_reg        <= dsr_next;
        red_cnt_reg    <= red_cnt_next;
        neg_reg        <= neg_next;
        tan_reg        <= tan_next;
        tsign_reg      <= tsign_next;
        del_idx_reg    <= del_idx_next;
        res_index_reg  <= res_index_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        startx_next     = startx_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        ent_next        = ent_reg;
        res_valid_next  = 1'b0;
        x_next          = x_reg;
        ent_data_next   = ent_data_reg;
        rem_next        = rem_reg;
        dsr_next        = dsr_reg;
        red_cnt_next    = red_cnt_reg;
        neg_next        = neg_reg;
        tan_next        = tan_reg;
        tsign_next      = tsign_reg;
        del_idx_next    = del_idx_reg;
        res_index_next  = res_index_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = ent_reg[IW-1:0];
        ram_wdata       = in_entry;
        ram_raddr       = ent_reg[IW-1:0];
        mul_start       = 1'b0;
        mul_mcand       = $signed({{2{x_reg[31]}}, x_reg});
        mul_mplier      = ent_data_reg.rate;
        div_start       = 1'b0;
        cor_start       = 1'b0;

        if (cfg_wr)
        begin
            if (paddr[2] == mstg_pkg::REG_START_X)
                startx_next = pwdata;
            else
                step_next = pwdata;
        end

        case (state_reg)
            mstg_pkg::S_IDLE:
            begin
                if (item_xfer)
                begin
                    // single-result items report with last set
                    res_value_next  = '0;
                    res_status_next = mstg_pkg::ST_OK;
                    res_last_next   = 1'b1;
                    res_index_next  = entry_index;
                    case (kind)
                        mstg_pkg::K_TICK:
                        begin
                            x_next   = pos_reg;
                            pos_next = pos_reg + step_reg;
                            ent_next = '0;
                            if (count_reg != '0)
                                state_next = mstg_pkg::S_READ;
                        end
                        mstg_pkg::K_APPEND:
                        begin
                            res_valid_next = 1'b1;
                            if (tbl_full)
                            begin
                                res_index_next  = '0;
                                res_status_next = mstg_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we         = 1'b1;
                                ram_waddr      = count_reg[IW-1:0];
                                res_index_next = cnt_ext[3:0];
                                count_next     = count_reg + 1'b1;
                            end
                        end
                        mstg_pkg::K_OVERWRITE:
                        begin
                            res_valid_next = 1'b1;
                            if (idx_ok)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = idx_ext[IW-1:0];
                            end
                            else
                                res_status_next = mstg_pkg::ST_RANGE;
                        end
                        mstg_pkg::K_DELETE:
                        begin
                            if (idx_ok)
                            begin
                                del_idx_next = entry_index;
                                ent_next     = idx_ext[CW-1:0];
                                state_next   = mstg_pkg::S_DEL_READ;
                            end
                            else
                            begin
                                res_valid_next  = 1'b1;
                                res_status_next = mstg_pkg::ST_RANGE;
                            end
                        end
                        mstg_pkg::K_RESTART:
                        begin
                            pos_next       = startx_reg;
                            res_index_next = '0;
                            res_valid_next = 1'b1;
                        end
                        default:
                        begin
                            // unused kinds are dropped
                        end
                    endcase
                end
            end

            mstg_pkg::S_READ:
            begin
                state_next = mstg_pkg::S_LATCH;
            end

            mstg_pkg::S_LATCH:
            begin
                ent_data_next = ram_rdata;
                mul_start     = 1'b1;
                mul_mplier    = ram_rdata.rate;
                state_next    = mstg_pkg::S_MUL_ANG;
            end

            mstg_pkg::S_MUL_ANG:
            begin
                if (mul_done)
                begin
                    rem_next     = ang_sum[58:0];
                    dsr_next     = mstg_pkg::ANGLE_OFS[57:0];
                    red_cnt_next = 5'(mstg_pkg::REDUCE_SHIFT);
                    state_next   = mstg_pkg::S_REDUCE;
                end
            end

            mstg_pkg::S_REDUCE:
            begin
                // one trial subtraction of 2*pi*2^j per cycle
                if (rem_reg >= {1'b0, dsr_reg})
                    rem_next = rem_reg - {1'b0, dsr_reg};
                dsr_next     = dsr_reg >> 1;
                red_cnt_next = red_cnt_reg - 5'd1;
                if (red_cnt_reg == '0)
                    state_next = mstg_pkg::S_FOLD;
            end

            mstg_pkg::S_FOLD:
            begin
                neg_next   = fold_neg;
                cor_start  = 1'b1;
                state_next = mstg_pkg::S_CORDIC;
            end

            mstg_pkg::S_CORDIC:
            begin
                if (cor_done)
                begin
                    tsign_next = fx[33] ^ fy[33];
                    mul_mplier = ent_data_reg.amp;
                    if (ent_data_reg.wave == mstg_pkg::WAVE_SIN ||
                        ent_data_reg.wave == mstg_pkg::WAVE_COS)
                    begin
                        tan_next   = 1'b0;
                        mul_mcand  = (ent_data_reg.wave == mstg_pkg::WAVE_SIN) ? fy : fx;
                        mul_start  = 1'b1;
                        state_next = mstg_pkg::S_MUL_OUT;
                    end
                    else if (fx == '0)
                    begin
                        // cosine zero: straight to the pole value
                        tan_next   = 1'b1;
                        mul_mcand  = $signed({{2{t_pole[31]}}, t_pole});
                        mul_start  = 1'b1;
                        state_next = mstg_pkg::S_MUL_OUT;
                    end
                    else
                    begin
                        tan_next   = 1'b1;
                        div_start  = 1'b1;
                        state_next = mstg_pkg::S_DIV;
                    end
                end
            end

            mstg_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    mul_mcand  = $signed({{2{t_val[31]}}, t_val});
                    mul_mplier = ent_data_reg.amp;
                    mul_start  = 1'b1;
                    state_next = mstg_pkg::S_MUL_OUT;
                end
            end

            mstg_pkg::S_MUL_OUT:
            begin
                if (mul_done)
                begin
                    res_valid_next  = 1'b1;
                    res_index_next  = ent_ext[3:0];
                    res_value_next  = out_value;
                    res_status_next = mstg_pkg::ST_OK;
                    res_last_next   = ent_last;
                    if (ent_last)
                        state_next = mstg_pkg::S_IDLE;
                    else
                    begin
                        ent_next   = ent_reg + 1'b1;
                        state_next = mstg_pkg::S_READ;
                    end
                end
            end

            mstg_pkg::S_DEL_READ:
            begin
                // move the next entry down, or finish
                ram_raddr = ent_next_addr(ent_reg);
                if ((ent_reg + 1'b1) < count_reg)
                    state_next = mstg_pkg::S_DEL_WRITE;
                else
                begin
                    count_next      = count_reg - 1'b1;
                    res_valid_next  = 1'b1;
                    res_index_next  = del_idx_reg;
                    res_value_next  = '0;
                    res_status_next = mstg_pkg::ST_OK;
                    res_last_next   = 1'b1;
                    state_next      = mstg_pkg::S_IDLE;
                end
            end

            mstg_pkg::S_DEL_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ent_reg[IW-1:0];
                ram_wdata  = ram_rdata;
                ent_next   = ent_reg + 1'b1;
                state_next = mstg_pkg::S_DEL_READ;
            end

            default:
            begin
                state_next = mstg_pkg::S_IDLE;
            end
        endcase
    end

    mstg_ram #(
        .WIDTH ($bits(mstg_pkg::entry_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mstg_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_mcand),
        .mplier (mul_mplier),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    mstg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({abs_y, 16'd0}),
        .den   (abs_x),
        .done  (div_done),
        .ovf   (div_ovf),
        .quot  (div_quot)
    );

    mstg_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .z_in    (z_fold),
        .done    (cor_done),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    assign busy         = state_reg != mstg_pkg::S_IDLE;
    assign result_valid = res_valid_reg;
    assign result_index = res_index_reg;
    assign value        = res_value_reg;
    assign status       = res_status_reg;
    assign last         = res_last_reg;

    // restart answers in the next cycle with a clean final result
    a_restart_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && kind == mstg_pkg::K_RESTART)
        |=> (result_valid && last && status == mstg_pkg::ST_OK))
        else $error("restart did not report next cycle");

    // a tick on an empty table gives nothing and stays ready
    a_empty_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && kind == mstg_pkg::K_TICK && count_reg == '0)
        |=> (!result_valid && !busy))
        else $error("empty tick produced activity");

    // error results always close their item
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != mstg_pkg::ST_OK) |-> last)
        else $error("error result without last");

    // live count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(count_reg) != count_reg) |-> (32'(count_reg) <= 32'(MAX_ENTRIES)))
        else $error("entry count out of range");

endmodule

/* src/mstg_ram.sv */
// mstg_ram: generic single write port, single read port ram with registered read
// depends on nothing

module mstg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

/* src/mstg_mul.sv */
// mstg_mul: bit-serial signed shift-add multiplier, one multiplier bit per cycle
// depends on nothing

module mstg_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [33:0] mcand,
    input  logic signed [23:0] mplier,
    output logic               done,
    output logic signed [57:0] prod
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic signed [57:0] mc_reg, mc_next;
    logic [23:0]        mp_reg, mp_next;
    logic signed [57:0] acc_reg, acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        acc_reg <= acc_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            mc_next   = {{24{mcand[33]}}, mcand};
            mp_next   = mplier;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            // top bit of the multiplier carries negative weight
            if (mp_reg[0])
            begin
                acc_next = (cnt_reg == 5'd23) ? acc_reg - mc_reg : acc_reg + mc_reg;
            end
            mc_next  = mc_reg <<< 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

/* src/mstg_div.sv */
// mstg_div: restoring divider, one quotient bit per cycle, flags quotients past 31 bits
// depends on nothing

module mstg_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [49:0] num,
    input  logic [33:0] den,
    output logic        done,
    output logic        ovf,
    output logic [30:0] quot
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [49:0] rem_reg, rem_next;
    logic [63:0] dsh_reg, dsh_next;
    logic [30:0] q_reg, q_next;
    logic        ovf_reg, ovf_next;
    logic        fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign fits = {14'd0, rem_reg} >= dsh_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = num;
            dsh_next  = {den, 30'd0};
            q_next    = '0;
            ovf_next  = {15'd0, num} >= {den, 31'd0};
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg[49:0];
            end
            q_next   = {q_reg[29:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd30)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign quot = q_reg;

endmodule

/* src/mstg_cordic.sv */
// mstg_cordic: rotation-mode cordic, one micro-rotation per cycle
// depends on mstg_pkg (gain, arctangent table)

module mstg_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [33:0] z_in,
    output logic               done,
    output logic signed [33:0] cos_out,
    output logic signed [33:0] sin_out
);

    localparam int KW = $clog2(CORDIC_STEPS);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [KW-1:0]      k_reg, k_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic signed [33:0] dx, dy, da;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign dx = y_reg >>> k_reg;
    assign dy = x_reg >>> k_reg;
    assign da = $signed({2'b00, mstg_pkg::atan_q30(5'(k_reg))});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            k_next    = '0;
            x_next    = mstg_pkg::CORDIC_GAIN_Q30;
            y_next    = '0;
            z_next    = z_in;
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - da;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + da;
            end
            k_next = k_reg + 1'b1;
            if (k_reg == KW'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = x_reg;
    assign sin_out = y_reg;

endmodule

/* verif/tb_multichannel_sinusoid_table_generator.sv */
// tb_multichannel_sinusoid_table_generator: self-checking bench for the sinusoid table generator
// depends on mstg_pkg and multichannel_sinusoid_table_generator; predicts every result in place
`timescale 1ns / 1ps

module tb_multichannel_sinusoid_table_generator;

    // one item on the command port
    typedef struct {
        logic [2:0]  kind;
        logic [3:0]  idx;
        logic [1:0]  wave;
        logic [23:0] amp;
        logic [23:0] rate;
        logic [19:0] ph;
        logic [23:0] lvl;
    } cmd_t;

    // one result transfer
    typedef struct {
        logic [3:0]  idx;
        logic [31:0] val;
        logic [1:0]  st;
        logic        lst;
    } res_t;

    localparam longint TWO_PI  = 64'sd26986075409;
    localparam longint PI      = 64'sd13493037705;
    localparam longint HALF_PI = 64'sd6746518852;
    localparam longint GAIN    = 64'sd652032874;
    localparam int     NSTEPS  = 16;
    localparam int     DEPTH   = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  kind = '0;
    logic [3:0]  entry_index = '0;
    logic [1:0]  wave_type = '0;
    logic [23:0] amplitude = '0;
    logic [23:0] angular_rate = '0;
    logic [19:0] phase = '0;
    logic [23:0] level = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        result_valid;
    logic [3:0]  result_index;
    logic [31:0] value;
    logic [1:0]  status;
    logic        last;

    multichannel_sinusoid_table_generator dut (.*);

    always #4 clk = ~clk;

    // shadow of the block's state
    logic [31:0] shadow_step = mstg_pkg::STEP_X_RESET;
    logic [31:0] shadow_start = mstg_pkg::START_X_RESET;
    logic [31:0] shadow_pos = mstg_pkg::START_X_RESET;
    int          shadow_count = 0;
    cmd_t        shadow_tab [DEPTH];

    cmd_t   pending_cmds [$];
    res_t   expected_results [$];
    int     error_count = 0;
    int     gap_left = 0;
    logic   took = 1'b0;
    logic   gaps_off = 1'b0;

    longint atan_tab [NSTEPS] = '{843314857, 497837830, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768};

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // A*f(w*x+C)+h for one entry
    function automatic logic [31:0] wave_value(cmd_t e, longint x);
        longint r, cx, cy, z, dx, dy, t, acc, f;
        logic   flip;
        r = longint'($signed(e.rate)) * x + longint'($signed(e.ph)) * 65536;
        flip = 1'b0;
        r = r % TWO_PI;
        if (r < 0)
            r += TWO_PI;
        if (r >= PI)
            r -= TWO_PI;
        // fold into [-pi/2, pi/2], sign of sin and cos flips
        if (r > HALF_PI)
        begin
            r -= PI;
            flip = 1'b1;
        end
        else if (r < -HALF_PI)
        begin
            r += PI;
            flip = 1'b1;
        end
        z = r >>> 2;
        cx = GAIN;
        cy = 0;
        for (int k = 0; k < NSTEPS; k++)
        begin
            dx = cy >>> k;
            dy = cx >>> k;
            if (z >= 0)
            begin
                cx -= dx;
                cy += dy;
                z -= atan_tab[k];
            end
            else
            begin
                cx += dx;
                cy -= dy;
                z += atan_tab[k];
            end
        end
        if (flip)
        begin
            cx = -cx;
            cy = -cy;
        end
        if (e.wave == mstg_pkg::WAVE_SIN || e.wave == mstg_pkg::WAVE_COS)
        begin
            f = (e.wave == mstg_pkg::WAVE_SIN) ? cy : cx;
            acc = (longint'($signed(e.amp)) * f + (64'sd1 <<< 29)) >>> 30;
            return 32'(clamp32(acc + longint'($signed(e.lvl))));
        end
        // tangent, saturated at the poles
        if (cx == 0)
            t = (cy >= 0) ? 64'sd2147483647 : -64'sd2147483647;
        else
        begin
            t = (cy * 65536) / cx;
            if (t > 64'sd2147483647)
                t = 64'sd2147483647;
            if (t < -64'sd2147483647)
                t = -64'sd2147483647;
        end
        acc = (longint'($signed(e.amp)) * t + 64'sd32768) >>> 16;
        return 32'(clamp32(acc + longint'($signed(e.lvl))));
    endfunction

    function automatic res_t mk_res(logic [3:0] i, logic [31:0] v, logic [1:0] s, logic l);
        res_t r;
        r.idx = i;
        r.val = v;
        r.st = s;
        r.lst = l;
        return r;
    endfunction

    // update the shadow table and queue the results one transfer causes
    task automatic predict_results(cmd_t c);
        longint x;
        x = longint'($signed(shadow_pos));
        case (c.kind)
            mstg_pkg::K_TICK:
            begin
                for (int i = 0; i < shadow_count; i++)
                    expected_results.push_back(mk_res(4'(i), wave_value(shadow_tab[i], x),
                        mstg_pkg::ST_OK, i == shadow_count - 1));
                shadow_pos = shadow_pos + shadow_step;
            end
            mstg_pkg::K_APPEND:
            begin
                if (shadow_count >= DEPTH)
                    expected_results.push_back(mk_res(4'd0, 32'd0, mstg_pkg::ST_FULL, 1'b1));
                else
                begin
                    shadow_tab[shadow_count] = c;
                    expected_results.push_back(mk_res(4'(shadow_count), 32'd0,
                        mstg_pkg::ST_OK, 1'b1));
                    shadow_count++;
                end
            end
            mstg_pkg::K_OVERWRITE, mstg_pkg::K_DELETE:
            begin
                if (int'(c.idx) >= shadow_count)
                    expected_results.push_back(mk_res(c.idx, 32'd0, mstg_pkg::ST_RANGE, 1'b1));
                else
                begin
                    if (c.kind == mstg_pkg::K_OVERWRITE)
                        shadow_tab[c.idx] = c;
                    else
                    begin
                        for (int i = int'(c.idx); i + 1 < shadow_count; i++)
                            shadow_tab[i] = shadow_tab[i + 1];
                        shadow_count--;
                    end
                    expected_results.push_back(mk_res(c.idx, 32'd0, mstg_pkg::ST_OK, 1'b1));
                end
            end
            mstg_pkg::K_RESTART:
            begin
                shadow_pos = shadow_start;
                expected_results.push_back(mk_res(4'd0, 32'd0, mstg_pkg::ST_OK, 1'b1));
            end
            default:
                ; // unused kinds are dropped
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // driver: a new transfer is offered only once the previous one was taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && !took)
                ; // hold the current item
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_cmds.size() > 0 && !gaps_off && $urandom_range(0, 3) == 0)
            begin
                gap_left <= $urandom_range(0, 4);
                start <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                cmd_t c;
                c = pending_cmds.pop_front();
                kind <= c.kind;
                entry_index <= c.idx;
                wave_type <= c.wave;
                amplitude <= c.amp;
                angular_rate <= c.rate;
                phase <= c.ph;
                level <= c.lvl;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: prediction on each accepted item, checking on each result strobe
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took <= start && !busy;
            if (start && !busy)
            begin
                cmd_t c;
                c.kind = kind;
                c.idx = entry_index;
                c.wave = wave_type;
                c.amp = amplitude;
                c.rate = angular_rate;
                c.ph = phase;
                c.lvl = level;
                predict_results(c);
            end
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", {28'd0, result_index}, 32'd0);
                else
                begin
                    res_t w;
                    w = expected_results.pop_front();
                    if (result_index !== w.idx)
                        report_mismatch("result_index", {28'd0, result_index}, {28'd0, w.idx});
                    if (value !== w.val)
                        report_mismatch("value", value, w.val);
                    if (status !== w.st)
                        report_mismatch("status", {30'd0, status}, {30'd0, w.st});
                    if (last !== w.lst)
                        report_mismatch("last", {31'd0, last}, {31'd0, w.lst});
                end
            end
        end
    end

    // apb write: setup then access cycle
    task automatic reg_write(logic reg_sel, logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {reg_sel, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == mstg_pkg::REG_STEP_X)
            shadow_step = data;
        else
            shadow_start = data;
    endtask

    function automatic cmd_t mk_cmd(logic [2:0] k, logic [3:0] i, logic [1:0] w,
                                    logic [23:0] a, logic [23:0] r, logic [19:0] p,
                                    logic [23:0] l);
        cmd_t c;
        c.kind = k;
        c.idx = i;
        c.wave = w;
        c.amp = a;
        c.rate = r;
        c.ph = p;
        c.lvl = l;
        return c;
    endfunction

    // mostly table edits and ticks, a little restart and noise
    function automatic cmd_t random_cmd();
        int   sel;
        cmd_t c;
        c = mk_cmd(3'd0, 4'($urandom), 2'($urandom), 24'($urandom), 24'($urandom),
                   20'($urandom), 24'($urandom));
        sel = $urandom_range(0, 99);
        if (sel < 30)
            c.kind = mstg_pkg::K_APPEND;
        else if (sel < 55)
            c.kind = mstg_pkg::K_TICK;
        else if (sel < 75)
            c.kind = mstg_pkg::K_OVERWRITE;
        else if (sel < 90)
            c.kind = mstg_pkg::K_DELETE;
        else if (sel < 95)
            c.kind = mstg_pkg::K_RESTART;
        else
            c.kind = 3'($urandom_range(5, 7));
        if ((c.kind == mstg_pkg::K_OVERWRITE || c.kind == mstg_pkg::K_DELETE) &&
            $urandom_range(0, 2) != 0)
            c.idx = 4'($urandom_range(0, 5));
        // small rates now and then keep the angle near its start
        if ($urandom_range(0, 3) == 0)
            c.rate = 24'($signed(10'($urandom)));
        return c;
    endfunction

    // wait until every item is taken and every result has come, then let the block settle
    task automatic drain();
        do
            @(posedge clk);
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0);
        repeat (300) @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every kind, poles, full table, range errors
        pending_cmds.push_back(mk_cmd(mstg_pkg::K_TICK, 4'd0, mstg_pkg::WAVE_SIN,
                                      '0, '0, '0, '0));
        pending_cmds.push_back(mk_cmd(mstg_pkg::K_DELETE, 4'd0, mstg_pkg::WAVE_SIN,
                                      '0, '0, '0, '0));
        pending_cmds.push_back(mk_cmd(mstg_pkg::K_OVERWRITE, 4'd15, mstg_pkg::WAVE_SIN,
                                      '0, '0, '0, '0));
        pending_cmds.push_back(mk_cmd(mstg_pkg::K_APPEND, 4'd0, mstg_pkg::WAVE_SIN,
                                      24'h7fffff, 24'h7fffff, 20'h7ffff, 24'h7fffff));
        pending_cmds.push_back(mk_cmd(mstg_pkg::K_APPEND, 4'd0, mstg_pkg::WAVE_COS,
                                      24'h800000, 24'h800000, 20'h80000, 24'h800000));
        pending_cmds.push_back(mk_cmd(mstg_pkg::K_APPEND, 4'd0, mstg_pkg::WAVE_TAN,
                                      24'h7fffff, 24'd0, 20'd102944, 24'h7fffff));
        // undefined wave code behaves as tangent
        pending_cmds.push_back(mk_cmd(mstg_pkg::K_APPEND, 4'd0, 2'd3, 24'h800000, 24'd0,
                                      -20'sd102944, 24'h800000));
        pending_cmds.push_back(mk_cmd(mstg_pkg::K_APPEND, 4'd0, mstg_pkg::WAVE_TAN,
                                      24'h010000, 24'd0, 20'd0, 24'd0));
        pending_cmds.push_back(mk_cmd(mstg_pkg::K_TICK, 4'd0, mstg_pkg::WAVE_SIN,
                                      '0, '0, '0, '0));
        // undefined kinds
        pending_cmds.push_back(mk_cmd(3'd5, 4'd0, mstg_pkg::WAVE_SIN, '0, '0, '0, '0));
        pending_cmds.push_back(mk_cmd(3'd7, 4'hf, 2'd3, '1, '1, '1, '1));
        pending_cmds.push_back(mk_cmd(mstg_pkg::K_OVERWRITE, 4'd1, mstg_pkg::WAVE_TAN,
                                      24'h7fffff, 24'h000100, 20'h19220, 24'd0));
        pending_cmds.push_back(mk_cmd(mstg_pkg::K_DELETE, 4'd0, mstg_pkg::WAVE_SIN,
                                      '0, '0, '0, '0));
        pending_cmds.push_back(mk_cmd(mstg_pkg::K_RESTART, 4'd0, mstg_pkg::WAVE_SIN,
                                      '0, '0, '0, '0));
        for (int i = 0; i < 13; i++)
            pending_cmds.push_back(mk_cmd(mstg_pkg::K_APPEND, 4'd0, 2'($urandom),
                                          24'($urandom), 24'($urandom), 20'($urandom),
                                          24'($urandom)));
        pending_cmds.push_back(mk_cmd(mstg_pkg::K_TICK, 4'd0, mstg_pkg::WAVE_SIN,
                                      '0, '0, '0, '0));
        pending_cmds.push_back(mk_cmd(mstg_pkg::K_DELETE, 4'd15, mstg_pkg::WAVE_SIN,
                                      '0, '0, '0, '0));
        drain();

        // random phases under several register settings, extremes included
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    reg_write(mstg_pkg::REG_STEP_X, 32'h7fff_ffff);
                    reg_write(mstg_pkg::REG_START_X, 32'h8000_0000);
                end
                1:
                begin
                    reg_write(mstg_pkg::REG_STEP_X, 32'h8000_0000);
                    reg_write(mstg_pkg::REG_START_X, 32'h7fff_ffff);
                end
                2:
                begin
                    reg_write(mstg_pkg::REG_STEP_X, 32'd0);
                    reg_write(mstg_pkg::REG_START_X, 32'hffff_ffff);
                end
                default:
                begin
                    reg_write(mstg_pkg::REG_STEP_X, $urandom);
                    reg_write(mstg_pkg::REG_START_X, $urandom);
                end
            endcase
            pending_cmds.push_back(mk_cmd(mstg_pkg::K_RESTART, 4'd0, mstg_pkg::WAVE_SIN,
                                          '0, '0, '0, '0));
            for (int i = 0; i < 96; i++)
                pending_cmds.push_back(random_cmd());
            if (ph == 3)
            begin
                // final stretch runs back to back
                wait (pending_cmds.size() < 30);
                @(negedge clk);
                gaps_off = 1'b1;
            end
            drain();
        end

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
